// ===== rtl/core/lzssd_pkg.sv =====
// Shared types and constants for the LZSS ring decompressor.
`timescale 1ns / 1ps
package lzssd_pkg;

  localparam int unsigned RingSize = 4096;
  localparam int unsigned RingAw   = 12;
  localparam int unsigned CntW     = RingAw + 1;
  localparam int unsigned SizeBits = 32;
  localparam int unsigned MinMatch = 3;

  localparam logic [RingAw-1:0] RingStartRst = RingAw'(RingSize - 18);
  localparam logic [31:0]       SizeMask     = 32'hFFFF_FFFF >> (32 - SizeBits);

  // Stream tag, first byte first.
  localparam logic [7:0] TagBytes [4] = '{8'h56, 8'h43, 8'h4C, 8'h5A};

  // Command queue between front and back.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = 2;

  // Register map (word index).
  localparam logic RegRingFill  = 1'b0;
  localparam logic RegRingStart = 1'b1;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_DONE   = 3'd1,
    ST_BADTAG = 3'd2,
    ST_ZERO   = 3'd3,
    ST_TRUNC  = 3'd4,
    ST_OVER   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_MATCH,
    CMD_NOTE,
    CMD_SETUP
  } cmd_kind_e;

  // data: literal byte, or fill byte for SETUP.
  // pos: match position, or start position for SETUP.
  // status: status of the final byte (LIT/MATCH) or of the note.
  // trunc: append a truncation result after this command.
  // count: bytes produced before this command.
  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        data;
    logic [RingAw-1:0] pos;
    logic [3:0]        len_m3;
    status_e           status;
    logic              trunc;
    logic [31:0]       count;
  } cmd_t;

endpackage

// ===== rtl/core/lzssd_front.sv =====
// Front end: header check and token parsing into back-end commands.
`timescale 1ns / 1ps
module lzssd_front import lzssd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic [7:0]        ring_fill_i,
  input  logic [RingAw-1:0] ring_start_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output cmd_t              q_cmd_o
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CONTROL,
    PH_LITERAL,
    PH_MATCH_LO,
    PH_MATCH_HI,
    PH_STOP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] target_q, target_d;
  logic [31:0] produced_q, produced_d;
  logic [31:0] remain_q, remain_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  low_q, low_d;

  logic        accept;
  logic        push;
  cmd_t        cmd;
  logic [31:0] tgt_base;
  logic [31:0] tgt_new;
  logic [2:0]  bit_nx;
  phase_e      nt_phase;
  logic [2:0]  nt_bit;
  logic [4:0]  mlen;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Next token after a finished literal or match.
  assign bit_nx   = bit_q + 3'd1;
  assign nt_phase = (bit_q == 3'd7) ? PH_CONTROL :
                    (ctrl_q[bit_nx] ? PH_LITERAL : PH_MATCH_LO);
  assign nt_bit   = (bit_q == 3'd7) ? bit_q : bit_nx;

  assign tgt_base = (hdr_cnt_q == 3'd0) ? 32'd0 : target_q;
  assign tgt_new  = tgt_base | (32'(in_byte_i) << {hdr_cnt_q[1:0], 3'b000});
  assign mlen     = 5'({1'b0, in_byte_i[3:0]}) + 5'(MinMatch);

  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    target_d   = target_q;
    produced_d = produced_q;
    remain_d   = remain_q;
    ctrl_d     = ctrl_q;
    bit_d      = bit_q;
    low_d      = low_q;
    push       = 1'b0;
    cmd        = '0;
    cmd.kind   = CMD_NOTE;
    cmd.status = ST_RUN;

    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          if (hdr_cnt_q == 3'd0) begin
            target_d   = 32'd0;
            produced_d = 32'd0;
          end
          if (!hdr_cnt_q[2]) begin
            if (in_byte_i != TagBytes[hdr_cnt_q[1:0]]) begin
              push       = 1'b1;
              cmd.kind   = CMD_NOTE;
              cmd.status = ST_BADTAG;
              cmd.count  = produced_d;
              phase_d    = PH_STOP;
            end else begin
              hdr_cnt_d = hdr_cnt_q + 3'd1;
            end
          end else begin
            target_d = tgt_new;
            if (hdr_cnt_q == 3'd7) begin
              if (tgt_new == 32'd0) begin
                push       = 1'b1;
                cmd.kind   = CMD_NOTE;
                cmd.status = ST_ZERO;
                cmd.count  = produced_d;
                phase_d    = PH_STOP;
              end else if (tgt_new > SizeMask) begin
                push       = 1'b1;
                cmd.kind   = CMD_NOTE;
                cmd.status = ST_OVER;
                cmd.count  = produced_d;
                phase_d    = PH_STOP;
              end else begin
                push       = 1'b1;
                cmd.kind   = CMD_SETUP;
                cmd.data   = ring_fill_i;
                cmd.pos    = ring_start_i;
                cmd.count  = 32'd0;
                ctrl_d     = 8'd0;
                bit_d      = 3'd0;
                produced_d = 32'd0;
                remain_d   = tgt_new;
                phase_d    = PH_CONTROL;
              end
            end else begin
              hdr_cnt_d = hdr_cnt_q + 3'd1;
            end
          end
        end
        PH_CONTROL: begin
          ctrl_d  = in_byte_i;
          bit_d   = 3'd0;
          phase_d = in_byte_i[0] ? PH_LITERAL : PH_MATCH_LO;
        end
        PH_LITERAL: begin
          push       = 1'b1;
          cmd.kind   = CMD_LIT;
          cmd.data   = in_byte_i;
          cmd.count  = produced_q;
          produced_d = produced_q + 32'd1;
          remain_d   = remain_q - 32'd1;
          if (remain_q == 32'd1) begin
            cmd.status = ST_DONE;
            phase_d    = PH_STOP;
          end else begin
            phase_d = nt_phase;
            bit_d   = nt_bit;
          end
        end
        PH_MATCH_LO: begin
          low_d   = in_byte_i;
          phase_d = PH_MATCH_HI;
        end
        PH_MATCH_HI: begin
          push = 1'b1;
          if ({27'd0, mlen} > remain_q) begin
            cmd.kind   = CMD_NOTE;
            cmd.status = ST_OVER;
            cmd.count  = produced_q;
            phase_d    = PH_STOP;
          end else begin
            cmd.kind   = CMD_MATCH;
            cmd.pos    = {in_byte_i[7:4], low_q};
            cmd.len_m3 = in_byte_i[3:0];
            cmd.count  = produced_q;
            produced_d = produced_q + {27'd0, mlen};
            remain_d   = remain_q - {27'd0, mlen};
            if (remain_q == {27'd0, mlen}) begin
              cmd.status = ST_DONE;
              phase_d    = PH_STOP;
            end else begin
              phase_d = nt_phase;
              bit_d   = nt_bit;
            end
          end
        end
        PH_STOP: begin
          phase_d = PH_STOP;
        end
        default: begin
          phase_d = PH_STOP;
        end
      endcase

      // End of stream: flag truncation unless finished or failed.
      if (in_last_i) begin
        if (phase_d != PH_STOP) begin
          if (push) begin
            cmd.trunc = 1'b1;
          end else begin
            push       = 1'b1;
            cmd.kind   = CMD_NOTE;
            cmd.status = ST_TRUNC;
            cmd.count  = produced_d;
          end
        end
        phase_d   = PH_HEADER;
        hdr_cnt_d = 3'd0;
      end
    end
  end

  assign q_push_o = push;
  assign q_cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_cnt_q  <= 3'd0;
      target_q   <= 32'd0;
      produced_q <= 32'd0;
      remain_q   <= 32'd0;
      ctrl_q     <= 8'd0;
      bit_q      <= 3'd0;
      low_q      <= 8'd0;
    end else begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      target_q   <= target_d;
      produced_q <= produced_d;
      remain_q   <= remain_d;
      ctrl_q     <= ctrl_d;
      bit_q      <= bit_d;
      low_q      <= low_d;
    end
  end

endmodule

// ===== rtl/core/lzssd_cmd_fifo.sv =====
// Small command queue between the parser and the copy engine.
`timescale 1ns / 1ps
module lzssd_cmd_fifo import lzssd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t               entry_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]   fill_q;

  assign full_o  = (fill_q == (QueueAw+1)'(QueueDepth));
  assign valid_o = (fill_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QueueAw'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueueAw'(1);
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + (QueueAw+1)'(1);
        2'b01:   fill_q <= fill_q - (QueueAw+1)'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command popped from empty queue");

endmodule

// ===== rtl/core/lzssd_back.sv =====
// Back end: history ring, match copy engine and output register.
`timescale 1ns / 1ps
module lzssd_back import lzssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        byte_valid_o,
  output logic        run_last_o,
  output status_e     status_o,
  output logic [31:0] byte_count_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COPY,
    S_TRUNC
  } state_e;

  logic [7:0] ring_mem [RingSize];

  state_e            state_q, state_d;
  logic              ovalid_q, ovalid_d;
  logic [7:0]        obyte_q, obyte_d;
  logic              obv_q, obv_d;
  logic              olast_q, olast_d;
  status_e           ostat_q, ostat_d;
  logic [31:0]       ocnt_q, ocnt_d;
  logic [31:0]       cnt_q, cnt_d;
  logic [RingAw-1:0] wp_q, wp_d;
  logic [RingAw-1:0] start_q, start_d;
  logic [7:0]        fill_q, fill_d;
  logic [CntW-1:0]   wrn_q, wrn_d;
  logic [RingAw-1:0] rpos_q, rpos_d;
  logic [4:0]        left_q, left_d;
  status_e           mstat_q, mstat_d;
  logic              mtrunc_q, mtrunc_d;
  logic              rdv_q, rdv_d;
  logic              fwd_q, fwd_d;
  logic [7:0]        fwd_byte_q, fwd_byte_d;
  logic [7:0]        rd_q;

  logic              adv;
  logic              pop;
  logic              ring_we;
  logic [7:0]        ring_wdata;
  logic              ring_re;
  logic [RingAw-1:0] ring_raddr;
  logic [RingAw-1:0] rel_pos;
  logic [7:0]        copy_byte;
  logic [CntW-1:0]   wrn_inc;

  assign adv       = !ovalid_q || out_ready_i;
  // Entries not written since stream start read as the fill byte.
  assign copy_byte = fwd_q ? fwd_byte_q : (rdv_q ? rd_q : fill_q);
  assign rel_pos   = ring_raddr - start_q;
  assign wrn_inc   = (wrn_q == CntW'(RingSize)) ? wrn_q : wrn_q + CntW'(1);

  always_comb begin
    state_d    = state_q;
    ovalid_d   = ovalid_q;
    obyte_d    = obyte_q;
    obv_d      = obv_q;
    olast_d    = olast_q;
    ostat_d    = ostat_q;
    ocnt_d     = ocnt_q;
    cnt_d      = cnt_q;
    wp_d       = wp_q;
    start_d    = start_q;
    fill_d     = fill_q;
    wrn_d      = wrn_q;
    rpos_d     = rpos_q;
    left_d     = left_q;
    mstat_d    = mstat_q;
    mtrunc_d   = mtrunc_q;
    pop        = 1'b0;
    ring_we    = 1'b0;
    ring_wdata = copy_byte;
    ring_re    = 1'b0;
    ring_raddr = rpos_q;

    if (adv) begin
      ovalid_d = 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            pop = 1'b1;
            case (cmd_i.kind)
              CMD_LIT: begin
                ovalid_d   = 1'b1;
                obyte_d    = cmd_i.data;
                obv_d      = 1'b1;
                olast_d    = !cmd_i.trunc;
                ostat_d    = cmd_i.status;
                ocnt_d     = cmd_i.count + 32'd1;
                cnt_d      = cmd_i.count + 32'd1;
                ring_we    = 1'b1;
                ring_wdata = cmd_i.data;
                wp_d       = wp_q + RingAw'(1);
                wrn_d      = wrn_inc;
                state_d    = cmd_i.trunc ? S_TRUNC : S_IDLE;
              end
              CMD_MATCH: begin
                ring_re    = 1'b1;
                ring_raddr = cmd_i.pos;
                rpos_d     = cmd_i.pos + RingAw'(1);
                left_d     = 5'({1'b0, cmd_i.len_m3}) + 5'(MinMatch);
                mstat_d    = cmd_i.status;
                mtrunc_d   = cmd_i.trunc;
                cnt_d      = cmd_i.count;
                state_d    = S_COPY;
              end
              CMD_SETUP: begin
                fill_d  = cmd_i.data;
                start_d = cmd_i.pos;
                wp_d    = cmd_i.pos;
                wrn_d   = '0;
                cnt_d   = cmd_i.count;
                state_d = cmd_i.trunc ? S_TRUNC : S_IDLE;
              end
              default: begin
                ovalid_d = 1'b1;
                obyte_d  = 8'd0;
                obv_d    = 1'b0;
                olast_d  = 1'b1;
                ostat_d  = cmd_i.status;
                ocnt_d   = cmd_i.count;
                cnt_d    = cmd_i.count;
              end
            endcase
          end
        end
        S_COPY: begin
          ovalid_d = 1'b1;
          obyte_d  = copy_byte;
          obv_d    = 1'b1;
          ocnt_d   = cnt_q + 32'd1;
          cnt_d    = cnt_q + 32'd1;
          ring_we  = 1'b1;
          wp_d     = wp_q + RingAw'(1);
          wrn_d    = wrn_inc;
          left_d   = left_q - 5'd1;
          if (left_q == 5'd1) begin
            olast_d = !mtrunc_q;
            ostat_d = mstat_q;
            state_d = mtrunc_q ? S_TRUNC : S_IDLE;
          end else begin
            olast_d = 1'b0;
            ostat_d = ST_RUN;
            ring_re = 1'b1;
            rpos_d  = rpos_q + RingAw'(1);
          end
        end
        S_TRUNC: begin
          ovalid_d = 1'b1;
          obyte_d  = 8'd0;
          obv_d    = 1'b0;
          olast_d  = 1'b1;
          ostat_d  = ST_TRUNC;
          ocnt_d   = cnt_q;
          state_d  = S_IDLE;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end

    // Read-side tags travel with the registered read data.
    rdv_d      = rdv_q;
    fwd_d      = fwd_q;
    fwd_byte_d = fwd_byte_q;
    if (ring_re) begin
      rdv_d      = ({1'b0, rel_pos} < wrn_q);
      fwd_d      = ring_we && (ring_raddr == wp_q);
      fwd_byte_d = ring_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wp_q] <= ring_wdata;
    end
    if (ring_re) begin
      rd_q <= ring_mem[ring_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ovalid_q   <= 1'b0;
      obyte_q    <= 8'd0;
      obv_q      <= 1'b0;
      olast_q    <= 1'b0;
      ostat_q    <= ST_RUN;
      ocnt_q     <= 32'd0;
      cnt_q      <= 32'd0;
      wp_q       <= RingStartRst;
      start_q    <= RingStartRst;
      fill_q     <= 8'd0;
      wrn_q      <= '0;
      rpos_q     <= '0;
      left_q     <= 5'd0;
      mstat_q    <= ST_RUN;
      mtrunc_q   <= 1'b0;
      rdv_q      <= 1'b0;
      fwd_q      <= 1'b0;
      fwd_byte_q <= 8'd0;
    end else begin
      state_q    <= state_d;
      ovalid_q   <= ovalid_d;
      obyte_q    <= obyte_d;
      obv_q      <= obv_d;
      olast_q    <= olast_d;
      ostat_q    <= ostat_d;
      ocnt_q     <= ocnt_d;
      cnt_q      <= cnt_d;
      wp_q       <= wp_d;
      start_q    <= start_d;
      fill_q     <= fill_d;
      wrn_q      <= wrn_d;
      rpos_q     <= rpos_d;
      left_q     <= left_d;
      mstat_q    <= mstat_d;
      mtrunc_q   <= mtrunc_d;
      rdv_q      <= rdv_d;
      fwd_q      <= fwd_d;
      fwd_byte_q <= fwd_byte_d;
    end
  end

  assign cmd_pop_o    = pop;
  assign out_valid_o  = ovalid_q;
  assign out_byte_o   = obyte_q;
  assign byte_valid_o = obv_q;
  assign run_last_o   = olast_q;
  assign status_o     = ostat_q;
  assign byte_count_o = ocnt_q;

  a_copy_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY) |-> (left_q != 5'd0))
    else $error("copy running with no bytes left");

  a_write_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |=> (ovalid_q && obv_q))
    else $error("ring written without an output byte");

  a_wrn_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrn_q <= CntW'(RingSize))
    else $error("written count beyond ring size");

endmodule

// ===== rtl/core/lzss_4k_ring_decompressor_core.sv =====
// Top level of the LZSS 4K-ring decompressor: config registers and front/back wiring.
`timescale 1ns / 1ps
// Usage:
//  - s_axis: one compressed byte per item (tdata[7:0]), tlast on the final
//    byte of a stream. A byte with tlast always ends the stream; the next
//    byte is taken as the first tag byte.
//  - m_axis: one result per item: expanded byte plus running byte count in
//    tdata, byte-valid flag and status in tuser, tlast on the last result
//    caused by one input byte. On an error status the consumer drops the
//    bytes already delivered for that stream.
//  - APB: ring_fill at 0x0, ring_start at 0x4; sampled when the last header
//    byte is parsed. Write only while the block is idle.
//  - Throughput: the parser takes one byte per cycle while the command queue
//    has room. The copy engine emits a literal as one result and a match of
//    length L (3..18) as L results after a first ring read, one ring read
//    and write per cycle while the receiver is ready; a truncation note adds
//    one result. A literal passes the command queue and the output register.
//  - Reset: ring start 4078, fill 0, parser waits for a tag. No clearing
//    pass: a written-count window marks stale ring entries as fill bytes.
//  - Receiver stall: the output register holds, the copy engine freezes,
//    and the parser keeps accepting until the queue is full.
module lzss_4k_ring_decompressor_core import lzssd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Compressed input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  // Expanded output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] out_byte, [39:8] byte_count
  output logic [3:0]  m_axis_tuser,   // [0] byte_valid, [3:1] status
  output logic        m_axis_tlast,   // run_last
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]        ring_fill_q;
  logic [RingAw-1:0] ring_start_q;
  logic              cfg_we;

  logic              q_full;
  logic              q_push;
  cmd_t              q_cmd_in;
  logic              q_valid;
  logic              q_pop;
  cmd_t              q_cmd_out;

  logic [7:0]        out_byte;
  logic              byte_valid;
  logic              run_last;
  status_e           status;
  logic [31:0]       byte_count;

  // Register file: word index taken from paddr[2].
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_fill_q  <= 8'd0;
      ring_start_q <= RingStartRst;
    end else if (cfg_we) begin
      case (paddr[2])
        RegRingFill:  ring_fill_q  <= pwdata[7:0];
        RegRingStart: ring_start_q <= pwdata[RingAw-1:0];
        default:      ring_fill_q  <= ring_fill_q;
      endcase
    end
  end

  assign prdata = (paddr[2] == RegRingStart) ? {20'd0, ring_start_q} : {24'd0, ring_fill_q};

  // Parser: header, control bits, token fields -> commands.
  lzssd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_last_i    (s_axis_tlast),
    .ring_fill_i  (ring_fill_q),
    .ring_start_i (ring_start_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd_in)
  );

  lzssd_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out)
  );

  // Copy engine with the history ring.
  lzssd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_i        (q_cmd_out),
    .cmd_pop_o    (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (out_byte),
    .byte_valid_o (byte_valid),
    .run_last_o   (run_last),
    .status_o     (status),
    .byte_count_o (byte_count)
  );

  assign m_axis_tdata = {byte_count, out_byte};
  assign m_axis_tuser = {status, byte_valid};
  assign m_axis_tlast = run_last;

endmodule
